@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define ERA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

@@ design/era_pkg.sv @@
// Types, constants and rounding helper for the Euler rotation datapath.
package era_pkg;

    localparam int ANG_W = 16;

    localparam logic [16:0] FULL_TURN = 17'd46080;
    localparam logic [15:0] QUARTER   = 16'd11520;
    localparam logic [15:0] HALF_TURN = 16'd23040;
    localparam logic [15:0] THREE_Q   = 16'd34560;
    localparam logic [13:0] EIGHTH    = 14'd5760;

    // pi/180 * 2^40
    localparam logic [34:0] DEG2RAD_K = 35'd19190098069;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    // Horner divisors and floor(2^32 / k) reciprocals
    localparam logic [7:0]  KSIN [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] RSIN [SIN_STEPS] = '{32'd39045157, 32'd59652323,
                                                 32'd102261126, 32'd214748364,
                                                 32'd715827882};
    localparam logic [7:0]  KCOS [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] RCOS [COS_STEPS] = '{32'd32537631, 32'd47721858,
                                                 32'd76695844, 32'd143165576,
                                                 32'd357913941, 32'd2147483648};

    localparam int TRIG_LAT = 22;
    localparam int ROT_LAT  = 7;
    localparam int PIPE_LAT = TRIG_LAT + ROT_LAT;

    typedef logic signed [25:0] trig_t;      // Q24 sine or cosine
    typedef logic signed [26:0] mat_t;       // Q24 matrix entry
    typedef logic signed [51:0] prod_t;      // product of two Q24 values

    typedef enum logic [3:0] {
        QUAD_0 = 4'b0001,
        QUAD_1 = 4'b0010,
        QUAD_2 = 4'b0100,
        QUAD_3 = 4'b1000
    } quad_t;

    typedef struct packed {
        logic  swap;
        quad_t quad;
    } oct_t;

    // Drop 24 fraction bits, rounding half away from zero.
    function automatic logic signed [63:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] h;
        h = 64'sd8388608;
        if (v >= 0)
            return (v + h) >>> 24;
        else
            return -((-v + h) >>> 24);
    endfunction

endpackage

@@ design/era_delay.sv @@
// Enabled shift line that delays a word by a fixed number of stages.
module era_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dl_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign q = dl_reg[N-1];

endmodule

@@ design/era_hstep.sv @@
// One Horner step t' = 1 - (X*t)/k in Q30, three register stages.
module era_hstep
    import era_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  k,
    input  logic [31:0] recip,
    input  logic [29:0] xsq_in,
    input  logic [30:0] t_in,
    output logic [29:0] xsq_out,
    output logic [30:0] t_out
);

    logic [60:0] p_reg;
    logic [29:0] x1_reg, x2_reg, x3_reg;
    logic [61:0] est_reg;
    logic [29:0] m_reg;
    logic [30:0] t_reg;

    logic [29:0] m;
    logic [29:0] q0;
    logic [37:0] qk;
    logic [37:0] rem;
    logic [30:0] quo;

    assign m = p_reg[59:30];

    always_comb
    begin
        q0  = est_reg[61:32];
        qk  = q0 * k;
        rem = 38'(m_reg) - qk;
        // estimate is low by at most one
        quo = (rem >= 38'(k)) ? 31'(q0) + 31'd1 : 31'(q0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= 61'(xsq_in) * 61'(t_in);
            x1_reg  <= xsq_in;
            est_reg <= 62'(m) * 62'(recip);
            m_reg   <= m;
            x2_reg  <= x1_reg;
            t_reg   <= Q30_ONE - quo;
            x3_reg  <= x2_reg;
        end
    end

    assign xsq_out = x3_reg;
    assign t_out   = t_reg;

endmodule

@@ design/era_trig.sv @@
// Pipelined sine and cosine of a degree angle, octant Taylor series, Q24 out.
module era_trig
    import era_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output trig_t                   sin_q,
    output trig_t                   cos_q
);

    // stage 0: reduce to an octant offset
    logic signed [17:0] a_ext;
    logic signed [17:0] r_s;
    logic [15:0]        r;
    logic [15:0]        f;
    quad_t              quad;
    oct_t               oct;
    logic [12:0]        fo;

    always_comb
    begin
        a_ext = {{2{angle[ANG_W-1]}}, angle};
        r_s   = angle[ANG_W-1] ? a_ext + 18'(FULL_TURN) : a_ext;
        r     = r_s[15:0];
        if (r >= THREE_Q)
        begin
            quad = QUAD_3;
            f    = r - THREE_Q;
        end
        else if (r >= HALF_TURN)
        begin
            quad = QUAD_2;
            f    = r - HALF_TURN;
        end
        else if (r >= QUARTER)
        begin
            quad = QUAD_1;
            f    = r - QUARTER;
        end
        else
        begin
            quad = QUAD_0;
            f    = r;
        end
        oct.swap = f > 16'(EIGHTH);
        oct.quad = quad;
        fo       = oct.swap ? 13'(QUARTER - f) : f[12:0];
    end

    logic [12:0] fo_reg;
    oct_t        oct_reg;
    logic [29:0] x_reg;
    logic [47:0] xk;
    logic [29:0] xsq_reg;
    logic [59:0] xx;

    assign xk = 48'(fo_reg) * 48'(DEG2RAD_K);
    assign xx = 60'(x_reg) * 60'(x_reg) + 60'h0000_0000_2000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fo_reg  <= fo;
            oct_reg <= oct;
            x_reg   <= xk[46:17];
            xsq_reg <= xx[59:30];
        end
    end

    // Horner chains
    logic [29:0] sx [SIN_STEPS+1];
    logic [30:0] st [SIN_STEPS+1];
    logic [29:0] cx [COS_STEPS+1];
    logic [30:0] ct [COS_STEPS+1];

    assign sx[0] = xsq_reg;
    assign st[0] = Q30_ONE;
    assign cx[0] = xsq_reg;
    assign ct[0] = Q30_ONE;

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        era_hstep u_step (
            .clk     (clk),
            .en      (en),
            .k       (KSIN[i]),
            .recip   (RSIN[i]),
            .xsq_in  (sx[i]),
            .t_in    (st[i]),
            .xsq_out (sx[i+1]),
            .t_out   (st[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        era_hstep u_step (
            .clk     (clk),
            .en      (en),
            .k       (KCOS[i]),
            .recip   (RCOS[i]),
            .xsq_in  (cx[i]),
            .t_in    (ct[i]),
            .xsq_out (cx[i+1]),
            .t_out   (ct[i+1])
        );
    end

    // line x up with the end of the sine chain
    logic [29:0] x_d;
    era_delay #(.W(30), .N(3*SIN_STEPS + 1)) u_xdly (
        .clk (clk),
        .en  (en),
        .d   (x_reg),
        .q   (x_d)
    );

    logic [60:0] sxt;
    logic [29:0] sq_reg;
    logic [29:0] sq_d;

    assign sxt = 61'(x_d) * 61'(st[SIN_STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sxt[59:30];
        end
    end

    era_delay #(.W(30), .N(3*(COS_STEPS - SIN_STEPS) - 1)) u_sdly (
        .clk (clk),
        .en  (en),
        .d   (sq_reg),
        .q   (sq_d)
    );

    oct_t oct_d;
    era_delay #(.W($bits(oct_t)), .N(TRIG_LAT - 2)) u_odly (
        .clk (clk),
        .en  (en),
        .d   (oct_reg),
        .q   (oct_d)
    );

    // final stage: round to Q24, undo octant and quadrant folding
    logic [30:0] sd_w;
    logic [30:0] cd_w;
    trig_t       sd, cd, s0, c0, sn, cs;

    always_comb
    begin
        sd_w = 31'(sq_d) + 31'd32;
        cd_w = ct[COS_STEPS] + 31'd32;
        sd   = 26'(sd_w[30:6]);
        cd   = 26'(cd_w[30:6]);
        s0   = oct_d.swap ? cd : sd;
        c0   = oct_d.swap ? sd : cd;
        case (oct_d.quad)
            QUAD_0:
            begin
                sn = s0;
                cs = c0;
            end
            QUAD_1:
            begin
                sn = c0;
                cs = -s0;
            end
            QUAD_2:
            begin
                sn = -s0;
                cs = -c0;
            end
            default:
            begin
                sn = -c0;
                cs = s0;
            end
        endcase
    end

    trig_t sin_reg, cos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sn;
            cos_reg <= cs;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

@@ design/era_rot.sv @@
// Rotation matrix build and matrix-vector product with negation and clamp.
module era_rot
    import era_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  trig_t                        sr,
    input  trig_t                        cr,
    input  trig_t                        sp,
    input  trig_t                        cp,
    input  trig_t                        sy,
    input  trig_t                        cy,
    input  logic signed [DATA_WIDTH-1:0] ax,
    input  logic signed [DATA_WIDTH-1:0] ay,
    input  logic signed [DATA_WIDTH-1:0] az,
    output logic signed [DATA_WIDTH-1:0] wx,
    output logic signed [DATA_WIDTH-1:0] wy,
    output logic signed [DATA_WIDTH-1:0] wz
);

    localparam int PW = $bits(mat_t) + DATA_WIDTH;
    localparam int AW = PW + 2;
    localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] LIM_LO = -(64'sd1 <<< (DATA_WIDTH - 1));

    // negated angles: a = -yaw, b = -pitch, c = -roll
    trig_t sa, ca, sb, cb, sc, cc;
    assign sa = -sy;
    assign ca = cy;
    assign sb = -sp;
    assign cb = cp;
    assign sc = -sr;
    assign cc = cr;

    // M1: pairwise products
    prod_t p_cacb_reg, p_casb_reg, p_sacb_reg, p_sasb_reg, p_sacc_reg;
    prod_t p_cacc_reg, p_sasc_reg, p_casc_reg, p_cbsc_reg, p_cbcc_reg;
    trig_t sc1_reg, cc1_reg, nsb1_reg;

    // M2: rounded pairs
    trig_t r_cacb_reg, r_casb_reg, r_sacb_reg, r_sasb_reg, r_sacc_reg;
    trig_t r_cacc_reg, r_sasc_reg, r_casc_reg, r_cbsc_reg, r_cbcc_reg;
    trig_t sc2_reg, cc2_reg, nsb2_reg;

    // M3: triple products
    prod_t q1_reg, q2_reg, q3_reg, q4_reg;
    trig_t r_sacc3_reg, r_sasc3_reg, r_cacc3_reg, r_casc3_reg;
    trig_t m00_3_reg, m10_3_reg, m20_3_reg, m21_3_reg, m22_3_reg;

    // M4: matrix, M5: products, M6: sums
    mat_t                  m_reg  [3][3];
    logic signed [PW-1:0]  pr_reg [3][3];
    logic signed [AW-1:0]  acc_reg [3];
    logic signed [DATA_WIDTH-1:0] w_reg [3];

    logic [3*DATA_WIDTH-1:0]      a_d;
    logic signed [DATA_WIDTH-1:0] v [3];

    era_delay #(.W(3*DATA_WIDTH), .N(4)) u_adly (
        .clk (clk),
        .en  (en),
        .d   ({ax, ay, az}),
        .q   (a_d)
    );

    assign v[0] = a_d[3*DATA_WIDTH-1:2*DATA_WIDTH];
    assign v[1] = a_d[2*DATA_WIDTH-1:DATA_WIDTH];
    assign v[2] = a_d[DATA_WIDTH-1:0];

    logic signed [63:0] res [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res[i] = -rnd24(64'(acc_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cacb_reg <= ca * cb;
            p_casb_reg <= ca * sb;
            p_sacb_reg <= sa * cb;
            p_sasb_reg <= sa * sb;
            p_sacc_reg <= sa * cc;
            p_cacc_reg <= ca * cc;
            p_sasc_reg <= sa * sc;
            p_casc_reg <= ca * sc;
            p_cbsc_reg <= cb * sc;
            p_cbcc_reg <= cb * cc;
            sc1_reg    <= sc;
            cc1_reg    <= cc;
            nsb1_reg   <= sp;

            r_cacb_reg <= 26'(rnd24(64'(p_cacb_reg)));
            r_casb_reg <= 26'(rnd24(64'(p_casb_reg)));
            r_sacb_reg <= 26'(rnd24(64'(p_sacb_reg)));
            r_sasb_reg <= 26'(rnd24(64'(p_sasb_reg)));
            r_sacc_reg <= 26'(rnd24(64'(p_sacc_reg)));
            r_cacc_reg <= 26'(rnd24(64'(p_cacc_reg)));
            r_sasc_reg <= 26'(rnd24(64'(p_sasc_reg)));
            r_casc_reg <= 26'(rnd24(64'(p_casc_reg)));
            r_cbsc_reg <= 26'(rnd24(64'(p_cbsc_reg)));
            r_cbcc_reg <= 26'(rnd24(64'(p_cbcc_reg)));
            sc2_reg    <= sc1_reg;
            cc2_reg    <= cc1_reg;
            nsb2_reg   <= nsb1_reg;

            q1_reg      <= r_casb_reg * sc2_reg;
            q2_reg      <= r_casb_reg * cc2_reg;
            q3_reg      <= r_sasb_reg * sc2_reg;
            q4_reg      <= r_sasb_reg * cc2_reg;
            r_sacc3_reg <= r_sacc_reg;
            r_sasc3_reg <= r_sasc_reg;
            r_cacc3_reg <= r_cacc_reg;
            r_casc3_reg <= r_casc_reg;
            m00_3_reg   <= r_cacb_reg;
            m10_3_reg   <= r_sacb_reg;
            m20_3_reg   <= nsb2_reg;
            m21_3_reg   <= r_cbsc_reg;
            m22_3_reg   <= r_cbcc_reg;

            m_reg[0][0] <= 27'(m00_3_reg);
            m_reg[0][1] <= 27'(rnd24(64'(q1_reg))) - 27'(r_sacc3_reg);
            m_reg[0][2] <= 27'(rnd24(64'(q2_reg))) + 27'(r_sasc3_reg);
            m_reg[1][0] <= 27'(m10_3_reg);
            m_reg[1][1] <= 27'(rnd24(64'(q3_reg))) + 27'(r_cacc3_reg);
            m_reg[1][2] <= 27'(rnd24(64'(q4_reg))) - 27'(r_casc3_reg);
            m_reg[2][0] <= 27'(m20_3_reg);
            m_reg[2][1] <= 27'(m21_3_reg);
            m_reg[2][2] <= 27'(m22_3_reg);

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pr_reg[i][j] <= PW'(m_reg[i][j]) * PW'(v[j]);
                end
                acc_reg[i] <= AW'(pr_reg[i][0]) + AW'(pr_reg[i][1]) + AW'(pr_reg[i][2]);
                // clamp to the signed output range
                if (res[i] > LIM_HI)
                    w_reg[i] <= DATA_WIDTH'(LIM_HI);
                else if (res[i] < LIM_LO)
                    w_reg[i] <= DATA_WIDTH'(LIM_LO);
                else
                    w_reg[i] <= res[i][DATA_WIDTH-1:0];
            end
        end
    end

    assign wx = w_reg[0];
    assign wy = w_reg[1];
    assign wz = w_reg[2];

endmodule

@@ design/euler_rotate_acceleration.sv @@
// Depth: 30 register stages from an accepted sample to the output register.
// One sample per cycle unless stalled; every stage of the 29-stage datapath is a register.
// The widest multiply is in a Horner step of the sine/cosine series (30x32, the reciprocal).
// A skid word behind the output register makes sample_stall a register.
// Reset (rst_n, async, low) clears the pipeline valid bits and the output and skid flags.
// Feedback: none; each sample is independent.
module euler_rotate_acceleration
    import era_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [ANG_W-1:0]      roll_angle,
    input  logic signed [ANG_W-1:0]      pitch_angle,
    input  logic signed [ANG_W-1:0]      yaw_angle,
    input  logic signed [DATA_WIDTH-1:0] accel_x,
    input  logic signed [DATA_WIDTH-1:0] accel_y,
    input  logic signed [DATA_WIDTH-1:0] accel_z,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] world_x,
    output logic signed [DATA_WIDTH-1:0] world_y,
    output logic signed [DATA_WIDTH-1:0] world_z
);

    logic en;
    logic skid_v_reg;
    logic out_v_reg;
    logic [PIPE_LAT-1:0] vld_reg;

    assign en = !skid_v_reg;

    trig_t sr, cr, sp, cp, sy, cy;

    era_trig u_roll (
        .clk   (clk),
        .en    (en),
        .angle (roll_angle),
        .sin_q (sr),
        .cos_q (cr)
    );

    era_trig u_pitch (
        .clk   (clk),
        .en    (en),
        .angle (pitch_angle),
        .sin_q (sp),
        .cos_q (cp)
    );

    era_trig u_yaw (
        .clk   (clk),
        .en    (en),
        .angle (yaw_angle),
        .sin_q (sy),
        .cos_q (cy)
    );

    logic [3*DATA_WIDTH-1:0] acc_d;

    era_delay #(.W(3*DATA_WIDTH), .N(TRIG_LAT)) u_acc_dly (
        .clk (clk),
        .en  (en),
        .d   ({accel_x, accel_y, accel_z}),
        .q   (acc_d)
    );

    logic signed [DATA_WIDTH-1:0] wx, wy, wz;

    era_rot #(.DATA_WIDTH(DATA_WIDTH)) u_rot (
        .clk (clk),
        .en  (en),
        .sr  (sr),
        .cr  (cr),
        .sp  (sp),
        .cp  (cp),
        .sy  (sy),
        .cy  (cy),
        .ax  (acc_d[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .ay  (acc_d[2*DATA_WIDTH-1:DATA_WIDTH]),
        .az  (acc_d[DATA_WIDTH-1:0]),
        .wx  (wx),
        .wy  (wy),
        .wz  (wz)
    );

    // valid bits travel with the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], sample_valid};
    end

    logic pipe_out;
    assign pipe_out = en && vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && result_stall)
        begin
            // output held: park an arriving word in the skid
            if (pipe_out)
                skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= pipe_out;
        end
    end

    logic signed [DATA_WIDTH-1:0] skid_reg [3];
    logic signed [DATA_WIDTH-1:0] out_reg  [3];

    always_ff @(posedge clk)
    begin
        if (out_v_reg && result_stall)
        begin
            if (pipe_out)
            begin
                skid_reg[0] <= wx;
                skid_reg[1] <= wy;
                skid_reg[2] <= wz;
            end
        end
        else if (skid_v_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg[0] <= wx;
            out_reg[1] <= wy;
            out_reg[2] <= wz;
        end
    end

    assign sample_stall = skid_v_reg;
    assign result_valid = out_v_reg;
    assign world_x      = out_reg[0];
    assign world_y      = out_reg[1];
    assign world_z      = out_reg[2];

endmodule

@@ design/era_chk.sv @@
// Port-level checker for the Euler rotation block, bound to the top level.
`include "assert_macros.svh"

module era_chk (
    input logic clk,
    input logic rst_n,
    input logic sample_stall,
    input logic result_valid,
    input logic result_stall
);

    // a stalled word stays offered
    `ERA_ASSERT_NXT(a_hold_valid, clk, rst_n, result_valid && result_stall, result_valid)

    // input stalls only while an output word is waiting
    `ERA_ASSERT_NOW(a_stall_has_word, clk, rst_n, sample_stall, result_valid)

    // input stall starts only after a stalled output
    `ERA_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(sample_stall),
                    $past(result_valid && result_stall))

    // a released output drains the skid word in the next cycle
    `ERA_ASSERT_NXT(a_skid_drain, clk, rst_n, sample_stall && !result_stall,
                    !sample_stall && result_valid)

endmodule

bind euler_rotate_acceleration era_chk u_era_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

@@ dv/euler_rotate_acceleration_test.sv @@
// Self-checking testbench for the Euler body-to-world acceleration rotator.
module euler_rotate_acceleration_test;
    import era_pkg::*;

    localparam int DW = 16;
    localparam int N_RANDOM = 1950;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic signed [DW-1:0]    ax;
        logic signed [DW-1:0]    ay;
        logic signed [DW-1:0]    az;
    } sample_t;

    typedef struct packed {
        logic signed [DW-1:0] wx;
        logic signed [DW-1:0] wy;
        logic signed [DW-1:0] wz;
    } world_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [ANG_W-1:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
    logic signed [DW-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [DW-1:0] world_x, world_y, world_z;

    sample_t pending_samples[$];
    world_t  expected_world[$];
    int      error_count = 0;
    bit      in_taken = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_phase = 0;

    euler_rotate_acceleration #(.DATA_WIDTH(DW)) DUT (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .world_x(world_x), .world_y(world_y), .world_z(world_z)
    );

    always #5 clk = ~clk;

    function automatic longint round_off(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint qmul(longint p, longint q);
        return round_off(p * q, 24);
    endfunction

    function automatic longint unsigned series(longint unsigned xsq, bit is_cos);
        longint unsigned t;
        int unsigned div;
        int n;
        t = longint'(1) << 30;
        n = is_cos ? 6 : 5;
        for (int i = 0; i < n; i++)
        begin
            if (is_cos)
                div = (i == 0) ? 132 : (i == 1) ? 90 : (i == 2) ? 56 :
                      (i == 3) ? 30 : (i == 4) ? 12 : 2;
            else
                div = (i == 0) ? 110 : (i == 1) ? 72 : (i == 2) ? 42 : (i == 3) ? 20 : 6;
            t = (longint'(1) << 30) - ((xsq * t) >> 30) / div;
        end
        return t;
    endfunction

    // sine and cosine in Q24 of an angle in degrees with 7 fraction bits
    function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
        longint r, q, f, s0, c0, sd, cd;
        longint unsigned x, xsq;
        r = ang % 46080;
        if (r < 0)
            r += 46080;
        q = r / 11520;
        f = r - q * 11520;
        x = (longint'(f <= 5760 ? f : 11520 - f) * 64'd19190098069) >> 17;
        xsq = (x * x + (longint'(1) << 29)) >> 30;
        sd = longint'((((x * series(xsq, 1'b0)) >> 30) + 32) >> 6);
        cd = longint'((series(xsq, 1'b1) + 32) >> 6);
        s0 = (f <= 5760) ? sd : cd;
        c0 = (f <= 5760) ? cd : sd;
        case (q)
            0:
            begin
                sn = s0;
                cs = c0;
            end
            1:
            begin
                sn = c0;
                cs = -s0;
            end
            2:
            begin
                sn = -s0;
                cs = -c0;
            end
            default:
            begin
                sn = -c0;
                cs = s0;
            end
        endcase
    endfunction

    function automatic world_t rotate_to_world(sample_t s);
        longint sr, cr, sp, cp, sy, cy, sa, ca, sb, cb, sc, cc, acc, r, lim;
        longint m[3][3];
        longint v[3];
        world_t w;
        sin_cos(s.roll, sr, cr);
        sin_cos(s.pitch, sp, cp);
        sin_cos(s.yaw, sy, cy);
        v[0] = s.ax; v[1] = s.ay; v[2] = s.az;
        sa = -sy; ca = cy; sb = -sp; cb = cp; sc = -sr; cc = cr;
        m[0][0] = qmul(ca, cb);
        m[0][1] = qmul(qmul(ca, sb), sc) - qmul(sa, cc);
        m[0][2] = qmul(qmul(ca, sb), cc) + qmul(sa, sc);
        m[1][0] = qmul(sa, cb);
        m[1][1] = qmul(qmul(sa, sb), sc) + qmul(ca, cc);
        m[1][2] = qmul(qmul(sa, sb), cc) - qmul(ca, sc);
        m[2][0] = -sb;
        m[2][1] = qmul(cb, sc);
        m[2][2] = qmul(cb, cc);
        lim = (longint'(1) << (DW - 1)) - 1;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
            r = -round_off(acc, 24);
            if (r > lim)
                r = lim;
            if (r < -lim - 1)
                r = -lim - 1;
            if (i == 0) w.wx = r[DW-1:0];
            else if (i == 1) w.wy = r[DW-1:0];
            else w.wz = r[DW-1:0];
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [15:0] pick_angle();
        int k;
        k = $urandom_range(9);
        case (k)
            0: return 16'($urandom);                       // any raw value, wraps
            1: return 16'(11520 * $signed($urandom_range(4)) - 23040);
            2: return 16'(5760 + $signed($urandom_range(2)) - 1);
            default: return 16'($signed($urandom_range(46080)) - 23040);
        endcase
    endfunction

    function automatic logic [15:0] pick_accel();
        int k;
        k = $urandom_range(7);
        case (k)
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    task automatic add_sample(input logic [15:0] r, p, y, x, yy, z);
        sample_t s;
        s.roll = r; s.pitch = p; s.yaw = y;
        s.ax = x; s.ay = yy; s.az = z;
        pending_samples = {pending_samples, s};
    endtask

    // driver: advance on acceptance, bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !in_taken)
            begin
                // hold stalled word
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                sample_t s;
                s = pending_samples.pop_front();
                roll_angle <= s.roll; pitch_angle <= s.pitch; yaw_angle <= s.yaw;
                accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
                sample_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(40);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
            end
            else
                sample_valid <= 1'b0;
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 200) % 3)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(3) == 0);
                default: result_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    // monitor: predict on accepted input, check on accepted output
    always @(posedge clk)
    begin
        in_taken <= sample_valid && !sample_stall;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                sample_t s;
                s.roll = roll_angle; s.pitch = pitch_angle; s.yaw = yaw_angle;
                s.ax = accel_x; s.ay = accel_y; s.az = accel_z;
                expected_world = {expected_world, rotate_to_world(s)};
            end
            if (result_valid && !result_stall)
            begin
                if (expected_world.size() == 0)
                    report_mismatch("unexpected word", world_x, 0);
                else
                begin
                    world_t w;
                    w = expected_world.pop_front();
                    if (world_x !== w.wx) report_mismatch("world_x", world_x, w.wx);
                    if (world_y !== w.wy) report_mismatch("world_y", world_y, w.wy);
                    if (world_z !== w.wz) report_mismatch("world_z", world_z, w.wz);
                end
            end
        end
    end

    initial
    begin
        int a[10];
        a = '{0, 23040, -23040, 5760, -5760, 11520, 34560, 16'sh7fff, 16'sh8000, 5759};
        for (int i = 0; i < 10; i++)
            add_sample(16'(a[i]), 16'(a[(i + 3) % 10]), 16'(a[(i + 7) % 10]),
                       16'h1000, 16'hf000, 16'h7fff);
        add_sample(16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff);
        add_sample(16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000);
        add_sample(16'd5760, 16'd5760, 16'd5760, 16'h7fff, 16'h8000, 16'h7fff);
        add_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_sample(16'd11520, 16'd23040, 16'd34560, 16'h8000, 16'h7fff, 16'h0000);
        add_sample(16'd1, 16'd2, 16'd3, 16'h0001, 16'h0002, 16'h0003);
        for (int i = 0; i < N_RANDOM; i++)
            add_sample(pick_angle(), pick_angle(), pick_angle(),
                       pick_accel(), pick_accel(), pick_accel());
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_samples.size() == 0 && !sample_valid);
        wait (expected_world.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ euler_rotate_acceleration.f @@
+incdir+design
design/era_pkg.sv
design/era_delay.sv
design/era_hstep.sv
design/era_trig.sv
design/era_rot.sv
design/euler_rotate_acceleration.sv
design/era_chk.sv
dv/euler_rotate_acceleration_test.sv
